FILE: src/proximity_adaptive_threshold_defines.svh
// Assertion macros shared by the proximity threshold block.
// Depends on nothing; files that check their own logic include it.
`ifndef PROXIMITY_ADAPTIVE_THRESHOLD_DEFINES_SVH
`define PROXIMITY_ADAPTIVE_THRESHOLD_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PAT_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define PAT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pat_pkg.sv
// Shared types, constants and the threshold rule of the proximity threshold block.
// Used by the serial multiplier, the serial divider and the top level.
package pat_pkg;

  localparam int PROX_W     = 11;
  localparam int COUNT_W    = 24;
  localparam int LUX_W      = 32;
  localparam int WF_W       = 8;
  localparam int WFC_W      = 16;
  localparam int BASE_W     = 12;
  localparam int SUM_W      = 13;
  localparam int CNT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Number of calibration samples averaged, from 1 to 3.
  localparam int CAL_SAMPLES = 3;

  localparam int PROD_W     = COUNT_W + WFC_W;
  localparam int MUL_B_W    = COUNT_W + WF_W;
  localparam int K1000_W    = COUNT_W + 10;
  localparam int DIV_W      = MUL_B_W + 3;
  localparam int DIV_CNT_W  = 6;
  localparam int DIVISOR_W  = 4;

  localparam logic [DIVISOR_W-1:0] LUX_DIVISOR = 4'd10;
  localparam logic [DIVISOR_W-1:0] CAL_DIVISOR = DIVISOR_W'(CAL_SAMPLES);

  localparam logic [PROX_W-1:0] LEVEL_CLAMP  = 11'd1500;
  localparam logic [PROX_W-1:0] NEAR_OFFSET  = 11'd250;
  localparam logic [PROX_W-1:0] FAR_OFFSET   = 11'd220;
  localparam logic [PROX_W-1:0] NEAR_CLAMPED = 11'd1800;
  localparam logic [PROX_W-1:0] FAR_CLAMPED  = 11'd1600;
  localparam logic [PROX_W-1:0] NEAR_RESET   = 11'd600;
  localparam logic [PROX_W-1:0] FAR_RESET    = 11'd500;
  localparam logic [PROX_W-1:0] THRESH_MAX   = 11'h7FF;
  localparam logic [BASE_W-1:0] BASE_RESET   = 12'd2047;
  localparam logic [BASE_W-1:0] BASE_FLOOR   = 12'd20;
  localparam logic [SUM_W-1:0]  BASE_MARGIN  = 13'd500;
  localparam logic [SUM_W-1:0]  REBASE_GAP   = 13'd100;

  localparam logic CMD_CAL    = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PROX_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CLEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CLEAR = 3'd4;

  typedef struct packed {
    logic               command;
    logic               prox_ready;
    logic               light_ready;
    logic [PROX_W-1:0]  prox_value;
    logic [COUNT_W-1:0] light_count;
    logic [COUNT_W-1:0] clear_count;
  } pat_in_t;

  typedef struct packed {
    logic              distance_valid;
    logic              distance;
    logic              chip_thresh_valid;
    logic [PROX_W-1:0] chip_thresh_up;
    logic [PROX_W-1:0] chip_thresh_down;
    logic              lux_valid;
    logic [LUX_W-1:0]  lux;
    logic              calibration_done;
    logic [PROX_W-1:0] near_threshold;
    logic [PROX_W-1:0] far_threshold;
  } pat_out_t;

  typedef struct packed {
    logic [PROX_W-1:0] high;
    logic [PROX_W-1:0] low;
  } pat_thr_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] mcand;
    logic [WFC_W-1:0]   mplier;
  } pat_mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] steps;
  } pat_div_req_t;

  // Thresholds that follow from a noise level.
  function automatic pat_thr_t thr_for_level(input logic [PROX_W-1:0] level);
    pat_thr_t t;
    if (level < LEVEL_CLAMP) begin
      t.high = level + NEAR_OFFSET;
      t.low  = level + FAR_OFFSET;
    end else begin
      t.high = NEAR_CLAMPED;
      t.low  = FAR_CLAMPED;
    end
    return t;
  endfunction

endpackage

FILE: src/pat_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pat_pkg for widths and the request struct.
module pat_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pat_pkg::pat_mul_req_t       req,
  output logic                        done,
  output logic [pat_pkg::PROD_W-1:0]  prod
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [pat_pkg::PROD_W-1:0]  mc_r, mc_nxt;
  logic [pat_pkg::WFC_W-1:0]   mp_r, mp_nxt;
  logic [pat_pkg::PROD_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      mc_nxt   = pat_pkg::PROD_W'(req.mcand);
      mp_nxt   = req.mplier;
    end else if (busy_r) begin
      // Stop as soon as no multiplier bits are left.
      if (mp_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (mp_r[0]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt = {mc_r[pat_pkg::PROD_W-2:0], 1'b0};
        mp_nxt = {1'b0, mp_r[pat_pkg::WFC_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: src/pat_div.sv
// Restoring divider by a small divisor, one quotient bit per cycle, MSB first.
// Depends on pat_pkg for widths and the request struct.
module pat_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pat_pkg::pat_div_req_t      req,
  output logic                       done,
  output logic [pat_pkg::DIV_W-1:0]  quot
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pat_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pat_pkg::DIV_W-1:0]       dvd_r, dvd_nxt;
  logic [pat_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [pat_pkg::DIVISOR_W-1:0]   dsr_r, dsr_nxt;
  logic [pat_pkg::DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [pat_pkg::DIVISOR_W:0]     trial;
  logic                            fits;

  assign trial = {rem_r, dvd_r[pat_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // The remainder stays below the divisor, so it fits in the narrow register.
        rem_nxt = fits ? pat_pkg::DIVISOR_W'(trial - {1'b0, dsr_r})
                       : pat_pkg::DIVISOR_W'(trial);
        quo_nxt = {quo_r[pat_pkg::DIV_W-2:0], fits};
        dvd_nxt = {dvd_r[pat_pkg::DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: src/proximity_adaptive_threshold.sv
// Proximity thresholds and lux: sequencer, state and result register; uses pat_pkg.
// A completing calibration runs 13 divide steps before its result is registered; a lux
// request runs up to two serial multiplies (16 and 8 bits) and 35 divide steps. One
// request at a time; the next is taken only once a result is registered, and that waits
// while an earlier result is still held with out_ready low.
// Synchronous active-low reset loads baseline 2047, thresholds 600/500, clears the
// calibration sum and count, and sets the registers to their defaults.
`include "proximity_adaptive_threshold_defines.svh"

module proximity_adaptive_threshold (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pat_pkg::pat_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pat_pkg::pat_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [pat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Configuration registers.
  logic                          prox_en_r, prox_en_nxt;
  logic                          light_en_r, light_en_nxt;
  logic                          use_clr_r, use_clr_nxt;
  logic [pat_pkg::WF_W-1:0]      wf_r, wf_nxt;
  logic [pat_pkg::WFC_W-1:0]     wfc_r, wfc_nxt;

  // Proximity state.
  logic [pat_pkg::BASE_W-1:0]    base_r, base_nxt;
  logic [pat_pkg::PROX_W-1:0]    high_thr_r, high_thr_nxt;
  logic [pat_pkg::PROX_W-1:0]    low_thr_r, low_thr_nxt;
  logic [pat_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [pat_pkg::SUM_W-1:0]     sum_r, sum_nxt;

  // Sequencer and result path.
  logic [2:0]                    state_r, state_nxt;
  logic                          is_cal_r, is_cal_nxt;
  logic [pat_pkg::COUNT_W-1:0]   als_r, als_nxt;
  logic [pat_pkg::K1000_W-1:0]   k1000_r, k1000_nxt;
  pat_pkg::pat_out_t             res_r, res_nxt;
  pat_pkg::pat_out_t             out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  pat_pkg::pat_mul_req_t         mul_req;
  logic                          mul_done;
  logic [pat_pkg::PROD_W-1:0]    mul_prod;
  pat_pkg::pat_div_req_t         div_req;
  logic                          div_done;
  logic [pat_pkg::DIV_W-1:0]     div_quot;

  logic [pat_pkg::SUM_W-1:0]     cal_sum;
  logic [pat_pkg::CNT_W-1:0]     cal_cnt;
  logic [pat_pkg::K1000_W-1:0]   als_wide;
  logic [pat_pkg::K1000_W-1:0]   als_x1000;
  logic [pat_pkg::PROX_W-1:0]    pv;
  logic [pat_pkg::PROX_W-1:0]    avg;
  logic                          rebase_ok;
  pat_pkg::pat_thr_t             thr_pv;
  pat_pkg::pat_thr_t             thr_avg;
  pat_pkg::pat_thr_t             thr_after;

  logic                          thr_ordered;
  logic                          cnt_in_range;
  logic                          load_out;
  logic                          out_loaded;

  pat_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign pv        = in_data.prox_value;
  assign cal_sum   = sum_r + pat_pkg::SUM_W'(pv);
  assign cal_cnt   = cnt_r + 1'b1;
  assign als_wide  = pat_pkg::K1000_W'(in_data.light_count);
  // 1000 = 1024 - 32 + 8
  assign als_x1000 = (als_wide << 10) - (als_wide << 5) + (als_wide << 3);
  assign rebase_ok = (base_r > pat_pkg::BASE_FLOOR) &&
                     ((pat_pkg::SUM_W'(pv) + pat_pkg::REBASE_GAP) < pat_pkg::SUM_W'(base_r));
  assign thr_pv    = pat_pkg::thr_for_level(pv);
  assign avg       = div_quot[pat_pkg::PROX_W-1:0];
  assign thr_avg   = pat_pkg::thr_for_level(avg);

  always_comb begin
    prox_en_nxt  = prox_en_r;
    light_en_nxt = light_en_r;
    use_clr_nxt  = use_clr_r;
    wf_nxt       = wf_r;
    wfc_nxt      = wfc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pat_pkg::REG_PROX_ENABLE:  prox_en_nxt  = cfg_wdata[0];
        pat_pkg::REG_LIGHT_ENABLE: light_en_nxt = cfg_wdata[0];
        pat_pkg::REG_USE_CLEAR:    use_clr_nxt  = cfg_wdata[0];
        pat_pkg::REG_WINDOW:       wf_nxt       = cfg_wdata[pat_pkg::WF_W-1:0];
        pat_pkg::REG_WINDOW_CLEAR: wfc_nxt      = cfg_wdata[pat_pkg::WFC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_nxt      = base_r;
    high_thr_nxt  = high_thr_r;
    low_thr_nxt   = low_thr_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    state_nxt     = state_r;
    is_cal_nxt    = is_cal_r;
    als_nxt       = als_r;
    k1000_nxt     = k1000_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_req       = '0;
    div_req       = '0;
    thr_after     = '{high: high_thr_r, low: low_thr_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt                = '0;
          res_nxt.near_threshold = high_thr_r;
          res_nxt.far_threshold  = low_thr_r;
          is_cal_nxt             = 1'b0;
          state_nxt              = S_DONE;
          if (in_data.command == pat_pkg::CMD_CAL) begin
            if (cal_cnt >= pat_pkg::CNT_W'(pat_pkg::CAL_SAMPLES)) begin
              // Last sample: average it on the divider before touching the baseline and thresholds.
              sum_nxt                   = '0;
              cnt_nxt                   = '0;
              is_cal_nxt                = 1'b1;
              res_nxt.calibration_done  = 1'b1;
              res_nxt.chip_thresh_valid = 1'b1;
              div_req.start             = 1'b1;
              div_req.dividend          = {cal_sum, {(pat_pkg::DIV_W-pat_pkg::SUM_W){1'b0}}};
              div_req.divisor           = pat_pkg::CAL_DIVISOR;
              div_req.steps             = pat_pkg::DIV_CNT_W'(pat_pkg::SUM_W);
              state_nxt                 = S_DIV;
            end else begin
              sum_nxt = cal_sum;
              cnt_nxt = cal_cnt;
            end
          end else begin
            if (prox_en_r && in_data.prox_ready) begin
              if (pv >= high_thr_r) begin
                res_nxt.distance_valid    = 1'b1;
                res_nxt.distance          = 1'b0;
                res_nxt.chip_thresh_valid = 1'b1;
                res_nxt.chip_thresh_up    = pat_pkg::THRESH_MAX;
                res_nxt.chip_thresh_down  = low_thr_r;
              end else if (pv <= low_thr_r) begin
                if (rebase_ok) begin
                  thr_after = thr_pv;
                end
                high_thr_nxt              = thr_after.high;
                low_thr_nxt               = thr_after.low;
                res_nxt.distance_valid    = 1'b1;
                res_nxt.distance          = 1'b1;
                res_nxt.chip_thresh_valid = 1'b1;
                res_nxt.chip_thresh_up    = thr_after.high;
                res_nxt.chip_thresh_down  = '0;
              end
            end
            res_nxt.near_threshold = thr_after.high;
            res_nxt.far_threshold  = thr_after.low;
            if (light_en_r && in_data.light_ready) begin
              res_nxt.lux_valid = 1'b1;
              als_nxt           = in_data.light_count;
              if (in_data.light_count != '0) begin
                mul_req.start = 1'b1;
                if (use_clr_r) begin
                  // Correction is negative or zero once wfc * clear >= 1000 * light.
                  mul_req.mcand  = in_data.clear_count;
                  mul_req.mplier = wfc_r;
                  k1000_nxt      = als_x1000;
                  state_nxt      = S_MUL_A;
                end else begin
                  mul_req.mcand  = in_data.light_count;
                  mul_req.mplier = pat_pkg::WFC_W'(wf_r);
                  state_nxt      = S_MUL_B;
                end
              end
            end
          end
        end
      end
      S_MUL_A: begin
        if (mul_done) begin
          if (mul_prod >= pat_pkg::PROD_W'(k1000_r)) begin
            state_nxt = S_DONE;
          end else begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = als_r;
            mul_req.mplier = pat_pkg::WFC_W'(wf_r);
            state_nxt      = S_MUL_B;
          end
        end
      end
      S_MUL_B: begin
        if (mul_done) begin
          // light * 8 * window over 10; the quotient always fits in 32 bits.
          div_req.start    = 1'b1;
          div_req.dividend = {mul_prod[pat_pkg::MUL_B_W-1:0], 3'b000};
          div_req.divisor  = pat_pkg::LUX_DIVISOR;
          div_req.steps    = pat_pkg::DIV_CNT_W'(pat_pkg::DIV_W);
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (is_cal_r) begin
            if (pat_pkg::SUM_W'(avg) < (pat_pkg::SUM_W'(base_r) + pat_pkg::BASE_MARGIN)) begin
              thr_after = thr_avg;
              base_nxt  = pat_pkg::BASE_W'(avg);
            end
            high_thr_nxt             = thr_after.high;
            low_thr_nxt              = thr_after.low;
            res_nxt.chip_thresh_up   = thr_after.high;
            res_nxt.chip_thresh_down = thr_after.low;
            res_nxt.near_threshold   = thr_after.high;
            res_nxt.far_threshold    = thr_after.low;
          end else begin
            res_nxt.lux = div_quot[pat_pkg::LUX_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prox_en_r   <= 1'b0;
      light_en_r  <= 1'b0;
      use_clr_r   <= 1'b1;
      wf_r        <= 8'd1;
      wfc_r       <= '0;
      base_r      <= pat_pkg::BASE_RESET;
      high_thr_r  <= pat_pkg::NEAR_RESET;
      low_thr_r   <= pat_pkg::FAR_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      state_r     <= S_IDLE;
      is_cal_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prox_en_r   <= prox_en_nxt;
      light_en_r  <= light_en_nxt;
      use_clr_r   <= use_clr_nxt;
      wf_r        <= wf_nxt;
      wfc_r       <= wfc_nxt;
      base_r      <= base_nxt;
      high_thr_r  <= high_thr_nxt;
      low_thr_r   <= low_thr_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      state_r     <= state_nxt;
      is_cal_r    <= is_cal_nxt;
      out_valid_r <= out_valid_nxt;
    end
    als_r   <= als_nxt;
    k1000_r <= k1000_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign thr_ordered  = high_thr_r > low_thr_r;
  assign cnt_in_range = cnt_r < pat_pkg::CNT_W'(pat_pkg::CAL_SAMPLES);
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_loaded   = out_valid_r && (state_r == S_IDLE);

  `PAT_ASSERT_ALWAYS(a_thr_order, clk, rst_n, thr_ordered, "near threshold not above far")
  `PAT_ASSERT_ALWAYS(a_cal_count, clk, rst_n, cnt_in_range, "calibration count not wrapped")
  `PAT_ASSERT_NEXT(a_result_load, clk, rst_n, load_out, out_loaded, "result not registered")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for proximity_adaptive_threshold: calibration, near/far reports,
// threshold re-basing and lux, checked against a predictor kept in the bench.
// Depends on pat_pkg and the proximity_adaptive_threshold RTL only.
module testbench;
  import pat_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  pat_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pat_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  proximity_adaptive_threshold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register copies as the block holds them after reset.
  logic             prox_en   = 1'b0;
  logic             light_en  = 1'b0;
  logic             use_clear = 1'b1;
  logic [WF_W-1:0]  wf        = 8'd1;
  logic [WFC_W-1:0] wfc       = 16'd0;

  // Predicted proximity state.
  logic [BASE_W-1:0] baseline = 12'd2047;
  logic [PROX_W-1:0] near_thr = 11'd600;
  logic [PROX_W-1:0] far_thr  = 11'd500;
  logic [CNT_W-1:0]  cal_count = '0;
  logic [SUM_W-1:0]  cal_sum   = '0;

  pat_in_t  sensor_requests[$];
  pat_out_t pending_outcomes[$];

  int error_count = 0;
  int accepted = 0;
  int results_seen = 0;
  int near_reports = 0;
  int far_reports = 0;
  int rebases = 0;
  int cals_taken = 0;
  int cals_rejected = 0;
  int lux_reports = 0;
  int lux_zero = 0;

  // Near and far thresholds that follow from a noise level.
  function automatic void set_levels(int unsigned level);
    if (level < 1500) begin
      near_thr = PROX_W'(level + 250);
      far_thr  = PROX_W'(level + 220);
    end else begin
      near_thr = 11'd1800;
      far_thr  = 11'd1600;
    end
  endfunction

  function automatic logic [LUX_W-1:0] expected_lux(logic [COUNT_W-1:0] als,
                                                    logic [COUNT_W-1:0] clr);
    longint unsigned ratio;
    longint unsigned scaled;
    if (als == 0) return '0;
    if (use_clear) begin
      ratio = (64'(wfc) * 64'(clr)) / 64'(als) / 1000;
      // The correction factor (1 - ratio) is zero or negative here.
      if (ratio >= 1) return '0;
    end
    scaled = 64'(als) * 8 * 64'(wf) / 10;
    if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
    return scaled[LUX_W-1:0];
  endfunction

  function automatic pat_out_t proximity_outcome(pat_in_t req);
    pat_out_t res;
    int unsigned avg;
    res = '0;
    if (req.command == CMD_CAL) begin
      cal_sum   = cal_sum + SUM_W'(req.prox_value);
      cal_count = cal_count + 1'b1;
      if (32'(cal_count) >= CAL_SAMPLES) begin
        avg = 32'(cal_sum) / CAL_SAMPLES;
        if (avg < 32'(baseline) + 500) begin
          baseline = BASE_W'(avg);
          set_levels(avg);
          cals_taken++;
        end else begin
          cals_rejected++;
        end
        cal_count = '0;
        cal_sum   = '0;
        res.calibration_done  = 1'b1;
        res.chip_thresh_valid = 1'b1;
        res.chip_thresh_up    = near_thr;
        res.chip_thresh_down  = far_thr;
      end
    end else begin
      if (prox_en && req.prox_ready) begin
        if (req.prox_value >= near_thr) begin
          res.distance_valid    = 1'b1;
          res.distance          = 1'b0;
          res.chip_thresh_valid = 1'b1;
          res.chip_thresh_up    = 11'h7FF;
          res.chip_thresh_down  = far_thr;
          near_reports++;
        end else if (req.prox_value <= far_thr) begin
          // A far sample well under the baseline pulls the thresholds down.
          if (baseline > 20 && 32'(req.prox_value) + 100 < 32'(baseline)) begin
            set_levels(32'(req.prox_value));
            rebases++;
          end
          res.distance_valid    = 1'b1;
          res.distance          = 1'b1;
          res.chip_thresh_valid = 1'b1;
          res.chip_thresh_up    = near_thr;
          res.chip_thresh_down  = '0;
          far_reports++;
        end
      end
      if (light_en && req.light_ready) begin
        res.lux_valid = 1'b1;
        res.lux = expected_lux(req.light_count, req.clear_count);
        lux_reports++;
        if (res.lux == 0) lux_zero++;
      end
    end
    res.near_threshold = near_thr;
    res.far_threshold  = far_thr;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(pat_out_t got);
    pat_out_t want;
    if (pending_outcomes.size() == 0) begin
      $error("result arrived with no request outstanding");
      error_count++;
    end else begin
      want = pending_outcomes.pop_front();
      check_field("distance_valid", want.distance_valid, got.distance_valid);
      check_field("distance", want.distance, got.distance);
      check_field("chip_thresh_valid", want.chip_thresh_valid, got.chip_thresh_valid);
      check_field("chip_thresh_up", want.chip_thresh_up, got.chip_thresh_up);
      check_field("chip_thresh_down", want.chip_thresh_down, got.chip_thresh_down);
      check_field("lux_valid", want.lux_valid, got.lux_valid);
      check_field("lux", want.lux, got.lux);
      check_field("calibration_done", want.calibration_done, got.calibration_done);
      check_field("near_threshold", want.near_threshold, got.near_threshold);
      check_field("far_threshold", want.far_threshold, got.far_threshold);
    end
    results_seen++;
  endtask

  // Calibration requests carry random noise in the fields the block ignores.
  function automatic pat_in_t make_cal(logic [PROX_W-1:0] pv);
    pat_in_t req;
    req.command     = CMD_CAL;
    req.prox_ready  = 1'($urandom);
    req.light_ready = 1'($urandom);
    req.prox_value  = pv;
    req.light_count = COUNT_W'($urandom);
    req.clear_count = COUNT_W'($urandom);
    return req;
  endfunction

  function automatic pat_in_t make_status(logic prdy, logic lrdy, logic [PROX_W-1:0] pv,
                                          logic [COUNT_W-1:0] als, logic [COUNT_W-1:0] clr);
    pat_in_t req;
    req.command     = CMD_STATUS;
    req.prox_ready  = prdy;
    req.light_ready = lrdy;
    req.prox_value  = pv;
    req.light_count = als;
    req.clear_count = clr;
    return req;
  endfunction

  function automatic pat_in_t random_status();
    logic [PROX_W-1:0] pv;
    logic [COUNT_W-1:0] als;
    logic [COUNT_W-1:0] clr;
    case ($urandom_range(0, 4))
      0: pv = PROX_W'($urandom);
      1: pv = PROX_W'($urandom_range(0, 300));
      2: pv = PROX_W'($urandom_range(200, 800));
      3: pv = PROX_W'($urandom_range(1400, 2047));
      default: pv = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
    endcase
    case ($urandom_range(0, 9))
      0: als = '0;
      1, 2: als = COUNT_W'($urandom_range(1, 1000));
      3: als = 24'hFF_FFFF;
      default: als = COUNT_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: clr = '0;
      1: clr = COUNT_W'($urandom_range(0, 100));
      2, 3: begin
        // Near the point where the clear-channel correction reaches zero.
        clr = als + COUNT_W'($urandom_range(0, 2)) - 1'b1;
        if (als == 0) clr = '0;
      end
      default: clr = COUNT_W'($urandom);
    endcase
    return make_status($urandom_range(0, 6) != 0, $urandom_range(0, 3) != 0, pv, als, clr);
  endfunction

  task automatic queue_random(int count);
    int made;
    int level;
    int pv_val;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 3))
        0: level = $urandom_range(0, 2047);
        1: level = $urandom_range(0, 60);
        2: level = $urandom_range(1400, 1600);
        default: level = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 99)) inside
        [0:24]: begin
          for (int k = 0; k < CAL_SAMPLES; k++) begin
            pv_val = level + $urandom_range(0, 4) - 2;
            if (pv_val < 0) pv_val = 0;
            if (pv_val > 2047) pv_val = 2047;
            sensor_requests.push_back(make_cal(PROX_W'(pv_val)));
          end
          made += CAL_SAMPLES;
        end
        [25:31]: begin
          // A stray sample shifts the calibration grouping.
          sensor_requests.push_back(make_cal(PROX_W'($urandom)));
          made++;
        end
        default: begin
          sensor_requests.push_back(random_status());
          made++;
        end
      endcase
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PROX_ENABLE:  prox_en   = value[0];
      REG_LIGHT_ENABLE: light_en  = value[0];
      REG_USE_CLEAR:    use_clear = value[0];
      REG_WINDOW:       wf        = value[WF_W-1:0];
      REG_WINDOW_CLEAR: wfc       = value[WFC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic pe, logic le, logic uc, logic [WF_W-1:0] w,
                                logic [WFC_W-1:0] wc);
    write_reg(REG_PROX_ENABLE, CFG_DATA_W'(pe));
    write_reg(REG_LIGHT_ENABLE, CFG_DATA_W'(le));
    write_reg(REG_USE_CLEAR, CFG_DATA_W'(uc));
    write_reg(REG_WINDOW, CFG_DATA_W'(w));
    write_reg(REG_WINDOW_CLEAR, wc);
  endtask

  task automatic wait_idle();
    while (sensor_requests.size() != 0 || in_valid || pending_outcomes.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(proximity_outcome(in_data));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sensor_requests.size() > 0) begin
          in_data  <= sensor_requests.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: the ready pattern changes every so often, and once it
  // holds off long enough for the block to back up onto its input.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  logic ready_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left  = LONG_HOLD;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(50, 150);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom);
          2: ready_next = (stall_phase % 7) < 4;
          default: ready_next = $urandom_range(0, 3) == 0;
        endcase
      end
      out_ready <= ready_next;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset both enables are off, so status requests report no distance and no lux.
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'h7FF, 24'hFF_FFFF, 24'h0));
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'h000, 24'd1000, 24'd5));
    wait_idle();

    apply_settings(1'b1, 1'b1, 1'b1, 8'd255, 16'hFFFF);
    // Thresholds at the reset values 600/500, baseline 2047.
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'd600, 24'h0, 24'h0));
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'h7FF, 24'hFF_FFFF, 24'hFF_FFFF));
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'd599, 24'hFF_FFFF, 24'h0));
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd500, 24'd7, 24'd7));
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd0, 24'd7, 24'd7));
    sensor_requests.push_back(make_status(1'b0, 1'b0, 11'h7FF, 24'hFF_FFFF, 24'h0));
    // A high calibration average clamps the thresholds at 1800/1600.
    repeat (3) sensor_requests.push_back(make_cal(11'd1500));
    // Re-basing needs the sample more than 100 under the baseline.
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd1400, 24'd0, 24'd0));
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd1399, 24'd0, 24'd0));
    // An average at baseline plus 500 or more is not taken.
    repeat (3) sensor_requests.push_back(make_cal(11'h7FF));
    sensor_requests.push_back(make_cal(11'd21));
    sensor_requests.push_back(make_cal(11'd21));
    sensor_requests.push_back(make_cal(11'd22));
    sensor_requests.push_back(make_status(1'b1, 1'b1, 11'd0, 24'd1, 24'd0));
    // With the baseline at 20 a far report leaves the thresholds alone.
    sensor_requests.push_back(make_cal(11'd20));
    sensor_requests.push_back(make_cal(11'd20));
    sensor_requests.push_back(make_cal(11'd21));
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd240, 24'd0, 24'd0));
    sensor_requests.push_back(make_status(1'b1, 1'b0, 11'd270, 24'd0, 24'd0));
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings(1'b1, 1'b1, 1'b0, 8'd255, 16'hFFFF);
        1: apply_settings(1'b1, 1'b1, 1'b0, 8'd0, 16'd0);
        2: apply_settings(1'b1, 1'b1, 1'b1, 8'd1, 16'd1000);
        3: apply_settings(1'b0, 1'b1, 1'b1, 8'd128, WFC_W'($urandom));
        4: apply_settings(1'b1, 1'b0, 1'b0, WF_W'($urandom), WFC_W'($urandom));
        default: apply_settings($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                                1'($urandom), WF_W'($urandom),
                                $urandom_range(0, 1) ? WFC_W'($urandom) : 16'd1000);
      endcase
      queue_random(115);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d requests, %0d near and %0d far reports, %0d re-based",
             accepted, near_reports, far_reports, rebases);
    $display("summary: %0d calibrations taken, %0d rejected, %0d lux values (%0d zero)",
             cals_taken, cals_rejected, lux_reports, lux_zero);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
